FILE: hw/rtl/kfsamp_pkg.sv
// kfsamp_pkg: shared constants, codes and helper functions of the keyframe sampler.
// Used by kfsamp_div, kfsamp_isqrt, kfsamp_cordic and keyframe_sampler. No dependencies.
`default_nettype none

package kfsamp_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Internal angle and weight format is Q2.30
  localparam int IQ           = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int SLERP_NEAR   = 1;

  // Shared divider: 33-bit operands, up to 30 quotient bits
  localparam int DIV_W  = 33;
  localparam int DIV_QW = 30;
  localparam int STEP_W = 5;

  // Square root: radicand 1.0 in Q?.60
  localparam int SQ_W = 61;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_KEY_COUNT  = 1'b0;
  localparam logic REG_VALUE_KIND = 1'b1;

  localparam logic [1:0] KIND_SCALAR = 2'd0;
  localparam logic [1:0] KIND_VEC3   = 2'd1;
  localparam logic [1:0] KIND_QUAT   = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  // atan(2^-k) in Q2.30
  function automatic logic [31:0] kfsamp_atan(input logic [STEP_W-1:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] kfsamp_sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7FFFFFFF)
      r = 32'sh7FFFFFFF;
    else if (v < -66'sh80000000)
      r = -32'sh80000000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kfsamp_store.sv
// kfsamp_store: keyframe memory, one time and four value words per slot.
// One write port, one registered read port. Depends on nothing.
`default_nettype none

module kfsamp_store #(
  parameter int AW = 6,
  parameter int DW = 160
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kfsamp_div.sv
// kfsamp_div: restoring fraction divider, one quotient bit per cycle.
// Gives floor(num * 2^steps / den) for num < den. Uses kfsamp_pkg.
`default_nettype none

module kfsamp_div
  import kfsamp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den,
  input  logic [STEP_W-1:0] steps,
  output logic              done,
  output logic [DIV_QW-1:0] quot
);

  logic              run;
  logic [DIV_W:0]    rem;
  logic [DIV_W-1:0]  dreg;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W:0]    rem2;
  logic              ge;

  assign rem2 = {rem[DIV_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, num};
        dreg <= den;
        quot <= '0;
        cnt  <= steps;
        run  <= 1'b1;
      end else if (run) begin
        rem  <= ge ? rem2 - {1'b0, dreg} : rem2;
        quot <= {quot[DIV_QW-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kfsamp_isqrt.sv
// kfsamp_isqrt: integer square root, one result bit per cycle.
// Radicand up to 2^60. Uses kfsamp_pkg.
`default_nettype none

module kfsamp_isqrt
  import kfsamp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQ_W-1:0] rad,
  output logic            done,
  output logic [30:0]     root
);

  logic            run;
  logic [SQ_W-1:0] v;
  logic [SQ_W:0]   r;
  logic [SQ_W:0]   bm;
  logic [SQ_W:0]   trial;
  logic            take;

  assign trial = r + bm;
  assign take  = {1'b0, v} >= trial;
  assign root  = r[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v   <= rad;
        r   <= '0;
        bm  <= (SQ_W+1)'(1) << (SQ_W - 1);
        run <= 1'b1;
      end else if (run) begin
        if (take) begin
          v <= v - trial[SQ_W-1:0];
          r <= (r >> 1) + bm;
        end else begin
          r <= r >> 1;
        end
        bm <= bm >> 2;
        if (bm == (SQ_W+1)'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kfsamp_cordic.sv
// kfsamp_cordic: shared CORDIC, vectoring (angle) or rotation (sine), 30 steps.
// Uses kfsamp_pkg for the arctangent table.
`default_nettype none

module kfsamp_cordic
  import kfsamp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       vec,
  input  logic signed [CORDIC_W-1:0] x0,
  input  logic signed [CORDIC_W-1:0] y0,
  input  logic signed [CORDIC_W-1:0] z0,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] y,
  output logic signed [CORDIC_W-1:0] z
);

  logic                       run;
  logic                       mode;
  logic [STEP_W-1:0]          k;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] xs, ys, at;
  logic                       u;

  always_comb begin
    xs = x >>> k;
    ys = y >>> k;
    at = CORDIC_W'(kfsamp_atan(k));
    // vectoring drives y to zero, rotation drives z to zero
    u  = mode ? ~y[CORDIC_W-1] : z[CORDIC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x0;
        y    <= y0;
        z    <= z0;
        mode <= vec;
        k    <= '0;
        run  <= 1'b1;
      end else if (run) begin
        x <= u ? x + ys : x - ys;
        y <= u ? y - xs : y + xs;
        z <= u ? z + at : z - at;
        if (k == STEP_W'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/keyframe_sampler.sv
// keyframe_sampler: keyframe table with linear interpolation and quaternion slerp.
// Uses kfsamp_pkg, kfsamp_store, kfsamp_div, kfsamp_isqrt, kfsamp_cordic.
//
// A write request stores one keyframe (time plus x, y, z, w, all signed Q16.16)
// into slot key_index; slots at or above MAX_KEYS are dropped. A sample
// request scans the first key_count keys (at most MAX_KEYS) one at a time for
// the first key whose time is not below the sample time, reading each key
// through the registered read port of the memory that holds the table. At or
// before the first key or past the last key the end value comes back at once.
// Between keys the fraction t = (time - t0) / (t1 - t0) comes out of a
// bit-serial divider, then a single 33x33 multiplier is reused for every
// product. The KIND_OTHER kind returns the earlier key's value unblended;
// quaternions on the slerp path run a dot product, a square root, one 30-step
// CORDIC angle pass, two 30-step CORDIC sine passes and up to two weight
// divides. The block takes no new request while a sample is in work; the
// result sits in an output register so the next request can be taken while
// it waits. An empty table answers result_valid low with all-zero components.
// Scalar results zero y, z, w and three-vector results zero w. Slots never
// written read back unknown data. Configuration writes are always accepted.
`default_nettype none

module keyframe_sampler
  import kfsamp_pkg::*;
#(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  // input requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [5:0]         key_index,
  input  logic signed [31:0] time_value,
  input  logic signed [31:0] val_x,
  input  logic signed [31:0] val_y,
  input  logic signed [31:0] val_z,
  input  logic signed [31:0] val_w,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int NW  = (CW > 7) ? CW : 7;
  localparam int IW  = (AW > 6) ? AW : 6;
  localparam int TSH = IQ - FRAC_BITS;
  localparam logic [30:0] ONE30 = 31'(1) << IQ;
  localparam logic signed [65:0] NEAR_LIM = 66'((1 << FRAC_BITS) - SLERP_NEAR);

  typedef enum logic [4:0] {
    S_IDLE, S_SADDR, S_SCMP, S_PADDR, S_PDATA, S_TDIV,
    S_DOT_M, S_DOT_ACC, S_DOT_CHK, S_SQ, S_SQ_WAIT, S_SQRT, S_ATAN,
    S_TH_M, S_TH_WAIT, S_SIN, S_WGT, S_WDIV,
    S_MUL_A, S_MUL_B, S_MIX_ACC, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [6:0] key_count;
  logic [1:0] value_kind;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count  <= '0;
      value_kind <= KIND_SCALAR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_COUNT:  key_count  <= cfg_data;
        REG_VALUE_KIND: value_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // keys in use, clamped to the table size
  logic [NW-1:0] n;
  assign n = (NW'(key_count) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);

  // keyframe memory
  logic          mem_we;
  logic [IW-1:0] widx;
  logic [AW-1:0] raddr;
  logic [159:0]  rdata;
  logic [NW-1:0] i;
  logic [NW-1:0] i_prev;

  assign in_ready = (state == S_IDLE);
  assign widx     = IW'(key_index);
  assign mem_we   = in_valid && in_ready && (command == CMD_WRITE) &&
                    (NW'(key_index) < NW'(MAX_KEYS));
  assign i_prev   = i - 1'b1;
  assign raddr    = (state == S_PADDR) ? i_prev[AW-1:0] : i[AW-1:0];

  kfsamp_store #(.AW(AW), .DW(160)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx[AW-1:0]),
    .wdata ({time_value, val_x, val_y, val_z, val_w}),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic signed [31:0] rd_time;
  logic signed [31:0] rd_val [4];
  assign rd_time   = rdata[159:128];
  assign rd_val[0] = rdata[127:96];
  assign rd_val[1] = rdata[95:64];
  assign rd_val[2] = rdata[63:32];
  assign rd_val[3] = rdata[31:0];

  // working registers
  logic signed [31:0] tm;
  logic signed [32:0] a [4];
  logic signed [32:0] b [4];
  logic signed [31:0] t1;
  logic signed [31:0] r [4];
  logic               rvalid;
  logic [1:0]         c;
  logic               pass;
  logic [30:0]        t30, wa, wb, d30, s;
  logic signed [65:0] acc;
  logic signed [32:0] th;
  logic signed [CORDIC_W-1:0] sv;

  // shared multiplier, registered product
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [30:0]        wlin;

  assign wlin = ONE30 - t30;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_DOT_M: begin ma = a[c]; mb = b[c]; end
      S_SQ:    begin ma = {2'b0, d30}; mb = {2'b0, d30}; end
      S_TH_M:  begin ma = th; mb = {2'b0, pass ? t30 : wlin}; end
      S_MUL_A: begin ma = a[c]; mb = {2'b0, wa}; end
      S_MUL_B: begin ma = b[c]; mb = {2'b0, wb}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // shared divider
  logic              div_start, div_done;
  logic [DIV_W-1:0]  dnum, dden;
  logic [STEP_W-1:0] dsteps;
  logic [DIV_QW-1:0] div_q;

  kfsamp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dden),
    .steps (dsteps),
    .done  (div_done),
    .quot  (div_q)
  );

  // square root
  logic            sq_start, sq_done;
  logic [SQ_W-1:0] sq_in;
  logic [30:0]     sq_root;

  kfsamp_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_in),
    .done  (sq_done),
    .root  (sq_root)
  );

  // CORDIC
  logic                       cor_start, cor_vec, cor_done;
  logic signed [CORDIC_W-1:0] cx, cy, cz, cor_y, cor_z;

  kfsamp_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .vec   (cor_vec),
    .x0    (cx),
    .y0    (cy),
    .z0    (cz),
    .done  (cor_done),
    .y     (cor_y),
    .z     (cor_z)
  );

  // combinational helpers
  logic [30:0]        t30_new;
  logic [30:0]        tq_sh;
  logic signed [65:0] dabs;
  logic [65:0]        dsh;
  logic signed [65:0] mix_sum, mix_sh, psh;
  logic               w_div;
  logic               w_take;
  logic [30:0]        w_new;

  always_comb begin
    tq_sh   = 31'(div_q) << TSH;
    t30_new = (dnum == dden) ? ONE30 : tq_sh;
    dabs    = acc[65] ? -acc : acc;
    dsh     = 66'(dabs) << TSH;
    mix_sum = acc + prod;
    mix_sh  = mix_sum >>> IQ;
    psh     = prod >>> IQ;
    // weight = sin / s, clamped to [0, 1]
    w_div   = !(sv <= 0) && (sv < $signed({3'b0, s}));
    if (state == S_WDIV)
      w_new = 31'(div_q);
    else if (sv <= 0)
      w_new = '0;
    else
      w_new = ONE30;
    w_take  = ((state == S_WGT) && !w_div) || ((state == S_WDIV) && div_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      cor_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      cor_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && command == CMD_SAMPLE) begin
            tm     <= time_value;
            i      <= '0;
            rvalid <= 1'b1;
            if (n == '0) begin
              rvalid <= 1'b0;
              for (int k = 0; k < 4; k++) r[k] <= '0;
              state  <= S_DONE;
            end else begin
              state <= S_SADDR;
            end
          end
        end

        S_SADDR: state <= S_SCMP;

        S_SCMP: begin
          if (rd_time < tm) begin
            if (NW'(i + 1'b1) == n) begin
              // past the last key
              for (int k = 0; k < 4; k++) r[k] <= rd_val[k];
              state <= S_DONE;
            end else begin
              i     <= i + 1'b1;
              state <= S_SADDR;
            end
          end else if (i == '0) begin
            // at or before the first key
            for (int k = 0; k < 4; k++) r[k] <= rd_val[k];
            state <= S_DONE;
          end else begin
            t1 <= rd_time;
            for (int k = 0; k < 4; k++) b[k] <= 33'(rd_val[k]);
            state <= S_PADDR;
          end
        end

        S_PADDR: state <= S_PDATA;

        S_PDATA: begin
          for (int k = 0; k < 4; k++) a[k] <= 33'(rd_val[k]);
          dnum      <= DIV_W'(33'(tm) - 33'(rd_time));
          dden      <= DIV_W'(33'(t1) - 33'(rd_time));
          dsteps    <= STEP_W'(FRAC_BITS);
          div_start <= 1'b1;
          state     <= S_TDIV;
        end

        S_TDIV: begin
          if (div_done) begin
            t30 <= t30_new;
            wa  <= ONE30 - t30_new;
            wb  <= t30_new;
            c   <= '0;
            acc <= '0;
            case (value_kind)
              KIND_OTHER: begin
                for (int k = 0; k < 4; k++) r[k] <= a[k][31:0];
                state <= S_DONE;
              end
              KIND_QUAT: begin
                if (t30_new[IQ]) begin
                  for (int k = 0; k < 4; k++) r[k] <= b[k][31:0];
                  state <= S_DONE;
                end else begin
                  state <= S_DOT_M;
                end
              end
              default: state <= S_MUL_A;
            endcase
          end
        end

        S_DOT_M: state <= S_DOT_ACC;

        S_DOT_ACC: begin
          acc <= acc + (prod >>> FRAC_BITS);
          c   <= c + 1'b1;
          state <= (c == 2'd3) ? S_DOT_CHK : S_DOT_M;
        end

        S_DOT_CHK: begin
          c <= '0;
          // take the shorter arc
          if (acc[65]) begin
            for (int k = 0; k < 4; k++) b[k] <= -b[k];
          end
          if (dabs < NEAR_LIM) begin
            d30   <= dsh[30:0];
            state <= S_SQ;
          end else begin
            state <= S_MUL_A;
          end
        end

        S_SQ: state <= S_SQ_WAIT;

        S_SQ_WAIT: begin
          sq_in    <= (SQ_W'(1) << (2 * IQ)) - prod[SQ_W-1:0];
          sq_start <= 1'b1;
          state    <= S_SQRT;
        end

        S_SQRT: begin
          if (sq_done) begin
            s <= sq_root;
            if (sq_root == '0) begin
              state <= S_MUL_A;
            end else begin
              cor_vec   <= 1'b1;
              cx        <= CORDIC_W'(d30);
              cy        <= CORDIC_W'(sq_root);
              cz        <= '0;
              cor_start <= 1'b1;
              state     <= S_ATAN;
            end
          end
        end

        S_ATAN: begin
          if (cor_done) begin
            th    <= cor_z[32:0];
            pass  <= 1'b0;
            state <= S_TH_M;
          end
        end

        S_TH_M: state <= S_TH_WAIT;

        S_TH_WAIT: begin
          cor_vec   <= 1'b0;
          cx        <= CORDIC_GAIN;
          cy        <= '0;
          cz        <= psh[CORDIC_W-1:0];
          cor_start <= 1'b1;
          state     <= S_SIN;
        end

        S_SIN: begin
          if (cor_done) begin
            sv    <= cor_y;
            state <= S_WGT;
          end
        end

        S_WGT: begin
          if (w_div) begin
            dnum      <= sv[DIV_W-1:0];
            dden      <= DIV_W'(s);
            dsteps    <= STEP_W'(IQ);
            div_start <= 1'b1;
            state     <= S_WDIV;
          end
        end

        S_WDIV: ;

        S_MUL_A: state <= S_MUL_B;

        S_MUL_B: begin
          acc   <= prod;
          state <= S_MIX_ACC;
        end

        S_MIX_ACC: begin
          r[c]  <= kfsamp_sat32(mix_sh);
          c     <= c + 1'b1;
          state <= (c == 2'd3) ? S_DONE : S_MUL_A;
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_valid <= rvalid;
            out_x        <= r[0];
            out_y        <= (value_kind == KIND_SCALAR) ? '0 : r[1];
            out_z        <= (value_kind == KIND_SCALAR) ? '0 : r[2];
            out_w        <= (value_kind == KIND_SCALAR || value_kind == KIND_VEC3) ?
                            '0 : r[3];
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // weight finished: first pass is the earlier key, second the later
      if (w_take) begin
        if (pass) begin
          wb    <= w_new;
          c     <= '0;
          state <= S_MUL_A;
        end else begin
          wa    <= w_new;
          pass  <= 1'b1;
          state <= S_TH_M;
        end
      end
    end
  end

endmodule

`default_nettype wire
